// ===== src/awm_pkg.sv =====
`timescale 1ns / 1ps

package awm_pkg;

    localparam int OPCODE_W = 2;
    localparam int LETTER_W = 5;
    localparam int START_W  = 20;

    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PATTERN = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TEXT    = 2'd2;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_PATTERN,
        K_TEXT
    } t_kind;

    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [LETTER_W-1:0] letter;
        logic                leave;
        logic                full;
        logic [START_W-1:0]  start;
    } t_item;

endpackage

// ===== src/anagram_window_matcher.sv =====
`timescale 1ns / 1ps

// Sliding-window anagram search over a stream of letter beats. Each input beat
// carries an opcode (clear, pattern letter, text letter) and a letter code.
// One beat is taken per clock while input ready is high. A beat passes three
// stages: the first updates the pattern length, text count and ring pointer
// and swaps the new text letter into the ring of recent text, the second
// reads the letter balances for the entering and the leaving letter from two
// small memories, the third writes the balances back and keeps the count of
// nonzero balances. A match passes the first and second stage registers into
// the output register. Input ready drops only in a cycle where a new match is
// due while the output register still holds one that has not been taken. A
// clear takes one beat; no clearing pass is needed after reset or clear.
module anagram_window_matcher
    import awm_pkg::*;
#(
    parameter int              MAX_PATTERN = 64,
    parameter longint unsigned MAX_TEXT    = 1048576,
    parameter int              ALPHABET    = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [LETTER_W-1:0] i_letter,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [START_W-1:0]  o_start_index
);

    t_item               s1;
    logic [LETTER_W-1:0] leave_letter;
    logic                emit;
    logic [START_W-1:0]  emit_start;
    logic                adv;
    logic                acc;

    logic               r_out_valid;
    logic [START_W-1:0] r_out_start;

    assign adv        = !(r_out_valid && !i_out_ready && emit);
    assign acc        = i_in_valid && adv;
    assign o_in_ready = adv;

    awm_front #(
        .MAX_PATTERN(MAX_PATTERN),
        .MAX_TEXT   (MAX_TEXT),
        .ALPHABET   (ALPHABET)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_acc         (acc),
        .i_opcode      (i_opcode),
        .i_letter      (i_letter),
        .o_s1          (s1),
        .o_leave_letter(leave_letter)
    );

    awm_balance #(
        .MAX_PATTERN(MAX_PATTERN),
        .ALPHABET   (ALPHABET)
    ) u_balance (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_s1          (s1),
        .i_leave_letter(leave_letter),
        .o_emit        (emit),
        .o_start       (emit_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit && adv) begin
            r_out_valid <= 1'b1;
            r_out_start <= emit_start;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_start_index = r_out_start;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

endmodule

// ===== src/awm_ram.sv =====
`timescale 1ns / 1ps

module awm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== src/awm_front.sv =====
`timescale 1ns / 1ps

module awm_front
    import awm_pkg::*;
#(
    parameter int              MAX_PATTERN = 64,
    parameter longint unsigned MAX_TEXT    = 1048576,
    parameter int              ALPHABET    = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_acc,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [LETTER_W-1:0] i_letter,
    output t_item               o_s1,
    output logic [LETTER_W-1:0] o_leave_letter
);

    localparam int PW  = $clog2(MAX_PATTERN + 1);
    localparam int RW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TW  = $clog2(MAX_TEXT + 1);
    localparam int SW0 = (TW > PW) ? TW : PW;
    localparam int SW  = (SW0 > START_W) ? SW0 : START_W;

    localparam logic [PW-1:0] PAT_MAX  = PW'(MAX_PATTERN);
    localparam logic [TW-1:0] TEXT_MAX = TW'(MAX_TEXT);

    logic [PW-1:0] r_pat_len, n_pat_len;
    logic [TW-1:0] r_txt_cnt, n_txt_cnt;
    logic [RW-1:0] r_ptr, n_ptr;
    t_item         r_s1, n_s1;

    logic          letter_ok;
    logic [RW-1:0] slot;
    logic [PW-1:0] slot_inc;
    logic [TW-1:0] cnt_inc;
    logic          ring_we;

    assign letter_ok = int'(i_letter) < ALPHABET;
    assign slot      = (PW'(r_ptr) >= r_pat_len) ? '0 : r_ptr;
    assign slot_inc  = PW'(slot) + PW'(1);
    assign cnt_inc   = r_txt_cnt + TW'(1);

    always_comb begin
        n_pat_len = r_pat_len;
        n_txt_cnt = r_txt_cnt;
        n_ptr     = r_ptr;
        ring_we   = 1'b0;
        n_s1      = '0;
        n_s1.kind = K_CLEAR;
        if (i_acc) begin
            unique case (i_opcode)
                OP_CLEAR: begin
                    n_pat_len = '0;
                    n_txt_cnt = '0;
                    n_ptr     = '0;
                    n_s1.valid = 1'b1;
                    n_s1.kind  = K_CLEAR;
                end
                OP_PATTERN: begin
                    if (letter_ok && r_txt_cnt == '0 && r_pat_len < PAT_MAX) begin
                        n_pat_len   = r_pat_len + PW'(1);
                        n_s1.valid  = 1'b1;
                        n_s1.kind   = K_PATTERN;
                        n_s1.letter = i_letter;
                    end
                end
                OP_TEXT: begin
                    if (letter_ok && r_txt_cnt < TEXT_MAX) begin
                        n_txt_cnt = cnt_inc;
                        if (r_pat_len != '0) begin
                            ring_we     = 1'b1;
                            n_ptr       = (slot_inc >= r_pat_len) ? '0 : RW'(slot_inc);
                            n_s1.valid  = 1'b1;
                            n_s1.kind   = K_TEXT;
                            n_s1.letter = i_letter;
                            n_s1.leave  = SW'(r_txt_cnt) >= SW'(r_pat_len);
                            n_s1.full   = SW'(cnt_inc) >= SW'(r_pat_len);
                            n_s1.start  = START_W'(SW'(cnt_inc) - SW'(r_pat_len));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len  <= '0;
            r_txt_cnt  <= '0;
            r_ptr      <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            r_pat_len <= n_pat_len;
            r_txt_cnt <= n_txt_cnt;
            r_ptr     <= n_ptr;
            if (i_adv) begin
                r_s1 <= n_s1;
            end
        end
    end

    // ring of recent text, the oldest window letter comes back on the overwrite
    awm_ram #(
        .WIDTH(LETTER_W),
        .DEPTH(MAX_PATTERN)
    ) u_ring (
        .i_clk      (i_clk),
        .i_wr_en    (ring_we),
        .i_wr_addr  (slot),
        .i_wr_data  (i_letter),
        .i_rd_en    (ring_we),
        .i_rd_addr_a(slot),
        .i_rd_addr_b(slot),
        .o_rd_data_a(o_leave_letter),
        .o_rd_data_b()
    );

    assign o_s1 = r_s1;

    a_pat_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat_len <= PAT_MAX)
        else $error("pattern length above limit");

    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat_len == '0 || PW'(r_ptr) < r_pat_len)
        else $error("ring pointer outside window");

    a_text_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_txt_cnt <= TEXT_MAX)
        else $error("text count past saturation");

endmodule

// ===== src/awm_balance.sv =====
`timescale 1ns / 1ps

module awm_balance
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 26
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_item               i_s1,
    input  logic [LETTER_W-1:0] i_leave_letter,
    output logic                o_emit,
    output logic [START_W-1:0]  o_start
);

    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int BW = $clog2(MAX_PATTERN + 1) + 1;
    localparam int NW = $clog2(ALPHABET + 1);

    localparam logic [NW-1:0] NZ_MAX = NW'(ALPHABET);

    // stage 1
    logic          s1_lv;
    logic [AW-1:0] e1;
    logic [AW-1:0] l1;

    // stage 2
    t_item               r_s2;
    logic                r_s2_lv;
    logic [AW-1:0]       r_s2_l;
    logic [ALPHABET-1:0] r_va, n_va;
    logic [ALPHABET-1:0] r_vb, n_vb;
    logic [NW-1:0]       r_nz, n_nz;
    logic                r_fa_en, r_fb_en;
    logic [AW-1:0]       r_fa_addr, r_fb_addr;
    logic [BW-1:0]       r_fa_data, r_fb_data;

    logic [AW-1:0] e2;
    logic [BW-1:0] ram_a_e, ram_a_l, ram_b_e, ram_b_l;
    logic [BW-1:0] ae, al, be, bl;
    logic [BW-1:0] bal_e, bal_l, bal_e_new, bal_l_new;
    logic [BW-1:0] a_new, b_new;
    logic          is_clr, is_pat, is_txt;
    logic          we_a, we_b, same;
    logic          trk_e, trk_l;
    logic          inc_e, dec_e, inc_l, dec_l;

    assign s1_lv = i_s1.valid && i_s1.kind == K_TEXT && i_s1.leave
                   && (int'(i_leave_letter) < ALPHABET);
    assign e1    = AW'(i_s1.letter);
    assign l1    = AW'(i_leave_letter);
    assign e2    = AW'(r_s2.letter);

    assign is_clr = r_s2.valid && r_s2.kind == K_CLEAR;
    assign is_pat = r_s2.valid && r_s2.kind == K_PATTERN;
    assign is_txt = r_s2.valid && r_s2.kind == K_TEXT;

    // newest write wins, then valid bit, else cleared value
    assign ae = (r_fa_en && r_fa_addr == e2)     ? r_fa_data
              : (r_va[e2]     ? ram_a_e : '0);
    assign be = (r_fb_en && r_fb_addr == e2)     ? r_fb_data
              : (r_vb[e2]     ? ram_b_e : '0);
    assign al = (r_fa_en && r_fa_addr == r_s2_l) ? r_fa_data
              : (r_va[r_s2_l] ? ram_a_l : '0);
    assign bl = (r_fb_en && r_fb_addr == r_s2_l) ? r_fb_data
              : (r_vb[r_s2_l] ? ram_b_l : '0);

    // balance is the sum of the entered side and the leaving side
    assign bal_e     = ae + be;
    assign bal_l     = al + bl;
    assign bal_e_new = is_pat ? bal_e + BW'(1) : bal_e - BW'(1);
    assign bal_l_new = bal_l + BW'(1);

    assign we_a  = is_pat || is_txt;
    assign we_b  = is_txt && r_s2_lv;
    assign a_new = is_pat ? ae + BW'(1) : ae - BW'(1);
    assign b_new = bl + BW'(1);

    // leaving and entering the same letter cancels out
    assign same  = r_s2_lv && (r_s2_l == e2);
    assign trk_e = we_a && !same;
    assign trk_l = we_b && !same;
    assign inc_e = trk_e && bal_e == '0;
    assign dec_e = trk_e && bal_e_new == '0;
    assign inc_l = trk_l && bal_l == '0;
    assign dec_l = trk_l && bal_l_new == '0;

    always_comb begin
        n_va = r_va;
        n_vb = r_vb;
        if (is_clr) begin
            n_va = '0;
            n_vb = '0;
            n_nz = '0;
        end else begin
            if (we_a) begin
                n_va[e2] = 1'b1;
            end
            if (we_b) begin
                n_vb[r_s2_l] = 1'b1;
            end
            n_nz = r_nz + NW'(inc_e) + NW'(inc_l) - NW'(dec_e) - NW'(dec_l);
        end
    end

    assign o_emit  = is_txt && r_s2.full && n_nz == '0;
    assign o_start = r_s2.start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_va       <= '0;
            r_vb       <= '0;
            r_nz       <= '0;
            r_fa_en    <= 1'b0;
            r_fb_en    <= 1'b0;
        end else if (i_adv) begin
            r_s2      <= i_s1;
            r_s2_lv   <= s1_lv;
            r_s2_l    <= l1;
            r_va      <= n_va;
            r_vb      <= n_vb;
            r_nz      <= n_nz;
            r_fa_en   <= we_a;
            r_fa_addr <= e2;
            r_fa_data <= a_new;
            r_fb_en   <= we_b;
            r_fb_addr <= r_s2_l;
            r_fb_data <= b_new;
        end
    end

    // entered side: pattern raises, text lowers
    awm_ram #(
        .WIDTH(BW),
        .DEPTH(ALPHABET)
    ) u_bal_a (
        .i_clk      (i_clk),
        .i_wr_en    (we_a && i_adv),
        .i_wr_addr  (e2),
        .i_wr_data  (a_new),
        .i_rd_en    (i_adv),
        .i_rd_addr_a(e1),
        .i_rd_addr_b(l1),
        .o_rd_data_a(ram_a_e),
        .o_rd_data_b(ram_a_l)
    );

    // leaving side: letters dropping out of the window
    awm_ram #(
        .WIDTH(BW),
        .DEPTH(ALPHABET)
    ) u_bal_b (
        .i_clk      (i_clk),
        .i_wr_en    (we_b && i_adv),
        .i_wr_addr  (r_s2_l),
        .i_wr_data  (b_new),
        .i_rd_en    (i_adv),
        .i_rd_addr_a(e1),
        .i_rd_addr_b(l1),
        .o_rd_data_a(ram_b_e),
        .o_rd_data_b(ram_b_l)
    );

    a_nz_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nz <= NZ_MAX)
        else $error("nonzero count above alphabet size");

    a_clear_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && is_clr |=> r_nz == '0 && r_va == '0 && r_vb == '0)
        else $error("clear left balance state behind");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import awm_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int ALPHA_SIZE     = 26;
    localparam int PATTERN_CAP    = 64;
    localparam int TEXT_CAP       = 1048576;
    localparam int RANDOM_BEATS   = 880;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_MAX     = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode;
    logic [LETTER_W-1:0] i_letter;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [START_W-1:0]  o_start_index;

    anagram_window_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_letter      (i_letter),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_start_index (o_start_index)
    );

    // predictor state
    logic signed [7:0]   tally [ALPHA_SIZE];
    logic [4:0]          tally_nonzero;
    logic [6:0]          pat_count;
    logic [20:0]         text_seen;
    logic [LETTER_W-1:0] window_ring [PATTERN_CAP];
    logic [5:0]          window_slot;
    logic [START_W-1:0]  match_starts [$];

    int err_count;
    int useful_beats;
    int idle_cycles;
    int in_gap_pct;
    int out_stall_pct;
    bit long_hold_req;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic void clear_tally();
        for (int i = 0; i < ALPHA_SIZE; i++) tally[i] = '0;
        tally_nonzero = '0;
        pat_count     = '0;
        text_seen     = '0;
        window_slot   = '0;
    endfunction

    function automatic void shift_tally(input logic [LETTER_W-1:0] idx,
                                        input logic signed [7:0] delta);
        logic was_zero;
        was_zero   = (tally[idx] == 0);
        tally[idx] = tally[idx] + delta;
        if (was_zero && tally[idx] != 0) tally_nonzero = tally_nonzero + 1'b1;
        else if (!was_zero && tally[idx] == 0) tally_nonzero = tally_nonzero - 1'b1;
    endfunction

    task automatic track_anagram_beat(input logic [OPCODE_W-1:0] op,
                                      input logic [LETTER_W-1:0] ltr);
        logic [LETTER_W-1:0] leaving;
        logic [20:0]         offset;
        if (op == OP_CLEAR) begin
            clear_tally();
            return;
        end
        if (op == OP_UNUSED || ltr >= ALPHA_SIZE) return;
        if (op == OP_PATTERN) begin
            if (text_seen == 0 && pat_count < PATTERN_CAP) begin
                shift_tally(ltr, 8'sd1);
                pat_count = pat_count + 1'b1;
            end
            return;
        end
        if (text_seen >= TEXT_CAP) return;
        if (pat_count == 0) begin
            text_seen = text_seen + 1'b1;
            return;
        end
        if (window_slot >= pat_count) window_slot = '0;
        if (text_seen >= pat_count) begin
            leaving = window_ring[window_slot];
            if (leaving < ALPHA_SIZE) shift_tally(leaving, 8'sd1);
        end
        shift_tally(ltr, -8'sd1);
        window_ring[window_slot] = ltr;
        window_slot = window_slot + 1'b1;
        if (window_slot >= pat_count) window_slot = '0;
        text_seen = text_seen + 1'b1;
        if (text_seen >= pat_count && tally_nonzero == 0) begin
            offset = text_seen - pat_count;
            match_starts = {match_starts, offset[START_W-1:0]};
        end
    endtask

    task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [LETTER_W-1:0] ltr);
        int gap;
        gap = 0;
        if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) gap = gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_letter   <= ltr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_anagram_beat(op, ltr);
        if (op == OP_CLEAR || (op != OP_UNUSED && ltr < ALPHA_SIZE))
            useful_beats++;
    endtask

    task automatic pause_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (match_starts.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [START_W-1:0] want,
                                   input logic [START_W-1:0] got);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("tb: %s start_index expected %0d got %0d", what, want, got);
    endtask

    // result checker
    always @(posedge i_clk) begin
        logic [START_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (match_starts.size() == 0) begin
                report_mismatch("unexpected", '0, o_start_index);
            end else begin
                want = match_starts.pop_front();
                if (o_start_index !== want) report_mismatch("wrong", want, o_start_index);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // receiver side
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
                i_out_ready <= 1'b0;
                n = gap_len();
                repeat (n) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_cases();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        // empty pattern
        send_beat(OP_CLEAR, 5'd0);
        send_beat(OP_TEXT, 5'd2);
        send_beat(OP_TEXT, 5'd0);
        send_beat(OP_CLEAR, 5'd31);
        // extremes and out-of-alphabet letters
        send_beat(OP_PATTERN, 5'd0);
        send_beat(OP_PATTERN, 5'd25);
        send_beat(OP_PATTERN, 5'd31);
        send_beat(OP_UNUSED, 5'd0);
        // partial window, then matches
        send_beat(OP_TEXT, 5'd25);
        send_beat(OP_TEXT, 5'd0);
        send_beat(OP_TEXT, 5'd26);
        send_beat(OP_TEXT, 5'd25);
        // late pattern letter
        send_beat(OP_PATTERN, 5'd1);
        send_beat(OP_TEXT, 5'd0);
        send_beat(OP_TEXT, 5'd1);
        send_beat(OP_UNUSED, 5'd31);
        send_beat(OP_CLEAR, 5'd0);
        send_beat(OP_PATTERN, 5'd16);
        send_beat(OP_TEXT, 5'd16);
        send_beat(OP_TEXT, 5'd15);
        send_beat(OP_TEXT, 5'd16);
        pause_input();
    endtask

    task automatic test_long_pattern();
        logic [LETTER_W-1:0] ltr;
        in_gap_pct    = 30;
        out_stall_pct = 30;
        send_beat(OP_CLEAR, 5'd0);
        // two beyond the pattern cap
        for (int i = 0; i < PATTERN_CAP + 2; i++) begin
            ltr = LETTER_W'(i % 3);
            send_beat(OP_PATTERN, ltr);
        end
        for (int i = 0; i < 80; i++) begin
            ltr = LETTER_W'(i % 3);
            send_beat(OP_TEXT, ltr);
        end
        pause_input();
    endtask

    task automatic test_output_backpressure();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_beat(OP_CLEAR, 5'd0);
        send_beat(OP_PATTERN, 5'd7);
        long_hold_req = 1'b1;
        repeat (40) send_beat(OP_TEXT, 5'd7);
        pause_input();
    endtask

    task automatic test_random_jobs();
        int                  first;
        int                  plen;
        int                  tlen;
        int                  span;
        int                  base;
        int                  r;
        logic [LETTER_W-1:0] ltr;
        logic [OPCODE_W-1:0] op;
        first = useful_beats;
        while (useful_beats - first < RANDOM_BEATS) begin
            in_gap_pct    = pick_pct();
            out_stall_pct = pick_pct();
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(9) != 0) send_beat(OP_CLEAR, 5'($urandom_range(31)));
                r = $urandom_range(19);
                if (r == 0) plen = $urandom_range(60, 70);
                else if (r < 3) plen = $urandom_range(7, 20);
                else plen = $urandom_range(1, 6);
                span = ($urandom_range(4) == 0) ? ALPHA_SIZE : $urandom_range(1, 4);
                base = $urandom_range(ALPHA_SIZE - span);
                for (int i = 0; i < plen; i++) begin
                    ltr = LETTER_W'(base + $urandom_range(span - 1));
                    send_beat(OP_PATTERN, ltr);
                end
                tlen = $urandom_range(plen, plen + 40);
                for (int i = 0; i < tlen; i++) begin
                    if ($urandom_range(49) == 0) begin
                        case ($urandom_range(2))
                            0: send_beat(OP_UNUSED, 5'($urandom_range(31)));
                            1: send_beat($urandom_range(1) ? OP_TEXT : OP_PATTERN,
                                         5'($urandom_range(26, 31)));
                            default: send_beat(OP_PATTERN, 5'($urandom_range(25)));
                        endcase
                    end else begin
                        ltr = LETTER_W'(base + $urandom_range(span - 1));
                        send_beat(OP_TEXT, ltr);
                    end
                end
            end else begin
                repeat (8) begin
                    op  = OPCODE_W'($urandom_range(3));
                    ltr = LETTER_W'($urandom_range(31));
                    send_beat(op, ltr);
                end
            end
        end
        pause_input();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_CLEAR;
        i_letter      = '0;
        err_count     = 0;
        useful_beats  = 0;
        idle_cycles   = 0;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        long_hold_req = 1'b0;
        clear_tally();
        for (int i = 0; i < PATTERN_CAP; i++) window_ring[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_long_pattern();
        test_output_backpressure();
        test_random_jobs();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_count += match_starts.size();
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/awm_pkg.sv
src/awm_ram.sv
src/awm_front.sv
src/awm_balance.sv
src/anagram_window_matcher.sv
sim/tb.sv
